@@ rtl/bmf_pkg.sv @@
// Shared types, constants and the reciprocal table of the box mean filter.
package bmf_pkg;

    // Transaction codes on the input channel
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Widths that cover the largest window (31) and tallest frame
    localparam int ROW_W       = 13;
    localparam int COL_SUM_W   = 13;
    localparam int BOX_SUM_W   = 18;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = BOX_SUM_W + RECIP_W;
    localparam int OUT_DEPTH   = 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] red;
        logic [COL_SUM_W-1:0] green;
        logic [COL_SUM_W-1:0] blue;
    } col_sum_t;

    typedef struct packed {
        logic [BOX_SUM_W-1:0] red;
        logic [BOX_SUM_W-1:0] green;
        logic [BOX_SUM_W-1:0] blue;
    } box_sum_t;

    typedef struct packed {
        logic [PROD_W-1:0] red;
        logic [PROD_W-1:0] green;
        logic [PROD_W-1:0] blue;
    } prod_t;

    typedef struct packed {
        logic end_of_frame;
        pix_t pix;
    } result_t;

    // ceil(2^RECIP_SHIFT / (d*d)) indexed by half window h, d = 2h+1
    localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
        RECIP_W'(((1 << RECIP_SHIFT) + 1   - 1) / 1),
        RECIP_W'(((1 << RECIP_SHIFT) + 9   - 1) / 9),
        RECIP_W'(((1 << RECIP_SHIFT) + 25  - 1) / 25),
        RECIP_W'(((1 << RECIP_SHIFT) + 49  - 1) / 49),
        RECIP_W'(((1 << RECIP_SHIFT) + 81  - 1) / 81),
        RECIP_W'(((1 << RECIP_SHIFT) + 121 - 1) / 121),
        RECIP_W'(((1 << RECIP_SHIFT) + 169 - 1) / 169),
        RECIP_W'(((1 << RECIP_SHIFT) + 225 - 1) / 225),
        RECIP_W'(((1 << RECIP_SHIFT) + 289 - 1) / 289),
        RECIP_W'(((1 << RECIP_SHIFT) + 361 - 1) / 361),
        RECIP_W'(((1 << RECIP_SHIFT) + 441 - 1) / 441),
        RECIP_W'(((1 << RECIP_SHIFT) + 529 - 1) / 529),
        RECIP_W'(((1 << RECIP_SHIFT) + 625 - 1) / 625),
        RECIP_W'(((1 << RECIP_SHIFT) + 729 - 1) / 729),
        RECIP_W'(((1 << RECIP_SHIFT) + 841 - 1) / 841),
        RECIP_W'(((1 << RECIP_SHIFT) + 961 - 1) / 961)
    };

endpackage

@@ rtl/bmf_cell.sv @@
// One cell of the column-sum chain: holds a column sum and taps it onto a shared bus.
module bmf_cell (
    input  logic               clk,
    input  logic               shift,
    input  logic               sel,
    input  bmf_pkg::col_sum_t  din,
    input  bmf_pkg::col_sum_t  tap_in,
    output bmf_pkg::col_sum_t  dout,
    output bmf_pkg::col_sum_t  tap_out
);
    import bmf_pkg::*;

    col_sum_t val_reg;

    // Advance the column sum to the neighbor
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            val_reg <= din;
        end
    end

    assign dout    = val_reg;
    assign tap_out = sel ? (tap_in | val_reg) : tap_in;

endmodule

@@ rtl/bmf_out_fifo.sv @@
// Output queue that decouples the filter pipeline from the result channel.
module bmf_out_fifo #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/box_mean_filter_rgb_unit.sv @@
// Box mean filter over a raster-order RGB stream, odd window, floor mean per channel.
// Usage: one input transaction per clock is sustained (pixel or flush) while in_ready is
// high; results come out in raster order after the pipeline and the output queue.
// A pixel writes a line store holding MAX_WINDOW rows and updates a running column
// sum per column (read from and written back to a column-sum memory); a chain of
// MAX_WINDOW+1 cells carries the recent column sums along a row so the window sum
// is kept as a running total, then one reciprocal multiply gives the floor mean.
// Pixels within half a window of the border pass through. Output is held back by
// (d/2)*W + d/2 pixels; flush transactions drain the tail once a frame is complete.
// An eight-entry output queue lets input continue while results wait. The user must
// write configuration only while the block holds no pending transaction; not enforced.
module box_mean_filter_rgb_unit #(
    parameter int MAX_WINDOW = 21,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic        end_of_frame
);
    import bmf_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int SW       = $clog2(MAX_WINDOW);
    localparam int AW       = SW + CW;
    localparam int PW       = CW + ROW_W + 1;
    localparam int WIN_CAP  = (MAX_WINDOW - 1) | 1;
    localparam int NC       = MAX_WINDOW + 1;
    localparam int LS_DEPTH = MAX_WINDOW << CW;
    localparam int FC_W     = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic          pix;
        logic          emit;
        logic          interior;
        logic          eof;
        logic [CW-1:0] col;
        logic          first_row;
        logic          sub_en;
        logic          col_first;
        logic          col_ge_d;
        logic          center_fwd;
        pix_t          px;
    } s1_t;

    typedef struct packed {
        logic pix;
        logic emit;
        logic interior;
        logic eof;
        logic col_first;
        logic col_ge_d;
        pix_t center;
    } s2_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic eof;
        pix_t center;
    } s3_t;

    // Configuration registers
    logic [4:0]       win_reg;
    logic [10:0]      fw_reg;
    logic [12:0]      fh_reg;

    // Position state
    logic [CW-1:0]    in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [SW-1:0]    in_slot_reg;
    logic [CW-1:0]    out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [SW-1:0]    out_slot_reg;
    logic [PW-1:0]    pend_reg;

    // Effective settings
    logic [4:0]       d_odd;
    logic [4:0]       d_eff;
    logic [3:0]       h_eff;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] ht_eff;
    logic [PW-1:0]    lag;

    // Accept-cycle logic
    logic             accept;
    logic             is_pix;
    logic             restart;
    logic [CW-1:0]    cur_in_col;
    logic [ROW_W-1:0] cur_in_row;
    logic [SW-1:0]    cur_in_slot;
    logic [CW-1:0]    cur_out_col;
    logic [ROW_W-1:0] cur_out_row;
    logic [SW-1:0]    cur_out_slot;
    logic [PW-1:0]    cur_pend;
    logic [PW-1:0]    pend_inc;
    logic [PW-1:0]    pend_next;
    logic             in_wrap;
    logic             out_wrap;
    logic [CW-1:0]    in_col_next;
    logic [ROW_W-1:0] in_row_next;
    logic [SW-1:0]    in_slot_next;
    logic [CW-1:0]    out_col_next;
    logic [ROW_W-1:0] out_row_next;
    logic [SW-1:0]    out_slot_next;
    logic             emit;
    logic             interior;
    logic [SW:0]      sub_slot_wide;
    logic [SW-1:0]    sub_slot;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    sub_addr;
    logic [AW-1:0]    ctr_addr;
    pix_t             in_px;

    // Memories and their read data
    pix_t             ls_mem [LS_DEPTH];
    col_sum_t         cs_mem [MAX_WIDTH];
    pix_t             sub_rd_reg;
    pix_t             ctr_rd_reg;
    col_sum_t         cs_rd_reg;
    logic             fwd_reg;
    col_sum_t         fwd_val_reg;

    // Pipeline
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    s1_t              s1_reg;
    s2_t              s2_reg;
    s3_t              s3_reg;
    s3_t              s4_reg;
    col_sum_t         cs_old;
    col_sum_t         col_sum_next;
    pix_t             center1;
    box_sum_t         box_reg;
    prod_t            prod_reg;
    logic [RECIP_W-1:0] recip;
    result_t          res;
    logic             push;

    // Chain of cells
    col_sum_t         cell_dout [NC];
    col_sum_t         tap_bus [NC+1];
    logic             chain_shift;

    // Output queue
    result_t          out_res;
    logic [FC_W-1:0]  fifo_count;
    logic [2:0]       inflight;

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 5'd1;
            fw_reg  <= 11'd640;
            fh_reg  <= 13'd480;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW: win_reg <= cfg_data[4:0];
                REG_WIDTH:  fw_reg  <= cfg_data[10:0];
                REG_HEIGHT: fh_reg  <= cfg_data[12:0];
                default:    ;
            endcase
        end
    end

    // Derive effective window, frame size and output lag
    always_comb
    begin
        d_odd = win_reg | 5'd1;
        d_eff = (32'(d_odd) > WIN_CAP) ? 5'(WIN_CAP) : d_odd;
        h_eff = d_eff[4:1];
        if (fw_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(fw_reg);
        end
        ht_eff = (fh_reg == '0) ? ROW_W'(1) : fh_reg;
        lag    = PW'(h_eff) * PW'(w_eff) + PW'(h_eff);
    end

    assign accept = in_valid && in_ready;
    assign is_pix = opcode == OP_PIXEL;
    assign in_px  = '{red: in_red, green: in_green, blue: in_blue};

    // Track input and output positions, decide emission
    always_comb
    begin
        restart      = is_pix && (in_row_reg >= ht_eff);
        cur_in_col   = restart ? '0 : in_col_reg;
        cur_in_row   = restart ? '0 : in_row_reg;
        cur_in_slot  = restart ? '0 : in_slot_reg;
        cur_out_col  = restart ? '0 : out_col_reg;
        cur_out_row  = restart ? '0 : out_row_reg;
        cur_out_slot = restart ? '0 : out_slot_reg;
        cur_pend     = restart ? '0 : pend_reg;

        in_wrap      = (WW'(cur_in_col) + WW'(1)) >= w_eff;
        in_col_next  = in_wrap ? '0 : cur_in_col + 1'b1;
        in_row_next  = in_wrap ? cur_in_row + 1'b1 : cur_in_row;
        in_slot_next = cur_in_slot;
        if (in_wrap)
        begin
            in_slot_next = (cur_in_slot == SW'(MAX_WINDOW - 1)) ? '0 : cur_in_slot + 1'b1;
        end

        out_wrap      = (WW'(cur_out_col) + WW'(1)) >= w_eff;
        out_col_next  = out_wrap ? '0 : cur_out_col + 1'b1;
        out_row_next  = out_wrap ? cur_out_row + 1'b1 : cur_out_row;
        out_slot_next = cur_out_slot;
        if (out_wrap)
        begin
            out_slot_next = (cur_out_slot == SW'(MAX_WINDOW - 1)) ? '0 : cur_out_slot + 1'b1;
        end

        pend_inc = cur_pend + 1'b1;
        if (is_pix)
        begin
            emit      = (cur_out_row < ht_eff) && (pend_inc > lag);
            pend_next = emit ? cur_pend : pend_inc;
        end
        else
        begin
            emit      = (in_row_reg >= ht_eff) && (out_row_reg < ht_eff);
            pend_next = emit ? cur_pend - 1'b1 : cur_pend;
        end

        interior = (cur_out_row >= ROW_W'(h_eff))
                && ((ROW_W + 1)'(cur_out_row) + (ROW_W + 1)'(h_eff) < (ROW_W + 1)'(ht_eff))
                && (32'(cur_out_col) >= 32'(h_eff))
                && (32'(cur_out_col) + 32'(h_eff) < 32'(w_eff));

        // Ring slot of the row d above the incoming pixel
        if (32'(cur_in_slot) >= 32'(d_eff))
        begin
            sub_slot_wide = (SW + 1)'(cur_in_slot) - (SW + 1)'(d_eff);
        end
        else
        begin
            sub_slot_wide = (SW + 1)'(cur_in_slot) + (SW + 1)'(MAX_WINDOW) - (SW + 1)'(d_eff);
        end
        sub_slot = sub_slot_wide[SW-1:0];
        wr_addr  = {cur_in_slot, cur_in_col};
        sub_addr = {sub_slot, cur_in_col};
        ctr_addr = {cur_out_slot, cur_out_col};
    end

    // Advance position state on each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end
        else if (accept)
        begin
            if (is_pix)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                in_slot_reg <= in_slot_next;
            end
            out_col_reg  <= emit ? out_col_next  : cur_out_col;
            out_row_reg  <= emit ? out_row_next  : cur_out_row;
            out_slot_reg <= emit ? out_slot_next : cur_out_slot;
            pend_reg     <= pend_next;
        end
    end

    // Line store: write the new pixel, read the leaving row and the center pixel
    always_ff @(posedge clk)
    begin
        if (accept && is_pix)
        begin
            ls_mem[wr_addr] <= in_px;
        end
        sub_rd_reg <= ls_mem[sub_addr];
        ctr_rd_reg <= ls_mem[ctr_addr];
    end

    // Column-sum store: read at accept, write back from stage one
    always_ff @(posedge clk)
    begin
        if (v1_reg && s1_reg.pix)
        begin
            cs_mem[s1_reg.col] <= col_sum_next;
        end
        cs_rd_reg   <= cs_mem[cur_in_col];
        fwd_reg     <= v1_reg && s1_reg.pix && (s1_reg.col == cur_in_col);
        fwd_val_reg <= col_sum_next;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Capture the transaction into stage one
    always_ff @(posedge clk)
    begin
        s1_reg.pix        <= is_pix;
        s1_reg.emit       <= emit;
        s1_reg.interior   <= interior;
        s1_reg.eof        <= out_row_next >= ht_eff;
        s1_reg.col        <= cur_in_col;
        s1_reg.first_row  <= cur_in_row == '0;
        s1_reg.sub_en     <= cur_in_row >= ROW_W'(d_eff);
        s1_reg.col_first  <= cur_in_col == '0;
        s1_reg.col_ge_d   <= 32'(cur_in_col) >= 32'(d_eff);
        s1_reg.center_fwd <= is_pix && (ctr_addr == wr_addr);
        s1_reg.px         <= in_px;
    end

    // Update the vertical column sum
    always_comb
    begin
        cs_old = fwd_reg ? fwd_val_reg : cs_rd_reg;
        col_sum_next.red   = (s1_reg.first_row ? '0 : cs_old.red)
                           + COL_SUM_W'(s1_reg.px.red)
                           - (s1_reg.sub_en ? COL_SUM_W'(sub_rd_reg.red) : '0);
        col_sum_next.green = (s1_reg.first_row ? '0 : cs_old.green)
                           + COL_SUM_W'(s1_reg.px.green)
                           - (s1_reg.sub_en ? COL_SUM_W'(sub_rd_reg.green) : '0);
        col_sum_next.blue  = (s1_reg.first_row ? '0 : cs_old.blue)
                           + COL_SUM_W'(s1_reg.px.blue)
                           - (s1_reg.sub_en ? COL_SUM_W'(sub_rd_reg.blue) : '0);
        center1 = s1_reg.center_fwd ? s1_reg.px : ctr_rd_reg;
    end

    // Chain of column sums along the row; the cell d columns back drives the tap bus
    assign chain_shift = v1_reg && s1_reg.pix;
    assign tap_bus[0]  = '0;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        bmf_cell u_cell (
            .clk     (clk),
            .shift   (chain_shift),
            .sel     (d_eff == 5'(k)),
            .din     ((k == 0) ? col_sum_next : cell_dout[(k == 0) ? 0 : k - 1]),
            .tap_in  (tap_bus[k]),
            .dout    (cell_dout[k]),
            .tap_out (tap_bus[k+1])
        );
    end

    // Stage two: running window sum along the row
    always_ff @(posedge clk)
    begin
        s2_reg.pix       <= s1_reg.pix;
        s2_reg.emit      <= s1_reg.emit;
        s2_reg.interior  <= s1_reg.interior;
        s2_reg.eof       <= s1_reg.eof;
        s2_reg.col_first <= s1_reg.col_first;
        s2_reg.col_ge_d  <= s1_reg.col_ge_d;
        s2_reg.center    <= center1;
        if (v2_reg && s2_reg.pix)
        begin
            box_reg.red   <= (s2_reg.col_first ? '0 : box_reg.red)
                           + BOX_SUM_W'(cell_dout[0].red)
                           - (s2_reg.col_ge_d ? BOX_SUM_W'(tap_bus[NC].red) : '0);
            box_reg.green <= (s2_reg.col_first ? '0 : box_reg.green)
                           + BOX_SUM_W'(cell_dout[0].green)
                           - (s2_reg.col_ge_d ? BOX_SUM_W'(tap_bus[NC].green) : '0);
            box_reg.blue  <= (s2_reg.col_first ? '0 : box_reg.blue)
                           + BOX_SUM_W'(cell_dout[0].blue)
                           - (s2_reg.col_ge_d ? BOX_SUM_W'(tap_bus[NC].blue) : '0);
        end
    end

    // Stage three: multiply by the reciprocal of d*d
    assign recip = RECIP_TABLE[h_eff];

    always_ff @(posedge clk)
    begin
        s3_reg.emit     <= s2_reg.emit;
        s3_reg.interior <= s2_reg.interior;
        s3_reg.eof      <= s2_reg.eof;
        s3_reg.center   <= s2_reg.center;
        s4_reg          <= s3_reg;
        prod_reg.red    <= PROD_W'(box_reg.red)   * PROD_W'(recip);
        prod_reg.green  <= PROD_W'(box_reg.green) * PROD_W'(recip);
        prod_reg.blue   <= PROD_W'(box_reg.blue)  * PROD_W'(recip);
    end

    // Stage four: pick mean or pass-through and queue the result
    always_comb
    begin
        res.end_of_frame = s4_reg.eof;
        if (s4_reg.interior)
        begin
            res.pix.red   = prod_reg.red[RECIP_SHIFT +: 8];
            res.pix.green = prod_reg.green[RECIP_SHIFT +: 8];
            res.pix.blue  = prod_reg.blue[RECIP_SHIFT +: 8];
        end
        else
        begin
            res.pix = s4_reg.center;
        end
        push = v4_reg && s4_reg.emit;
    end

    bmf_out_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    // Take input only while the queue has room for every result in flight
    assign inflight = 3'(v1_reg && s1_reg.emit) + 3'(v2_reg && s2_reg.emit)
                    + 3'(v3_reg && s3_reg.emit) + 3'(v4_reg && s4_reg.emit);
    assign in_ready = (FC_W'(fifo_count) + FC_W'(inflight)) < FC_W'(OUT_DEPTH);

    assign out_blue     = out_res.pix.blue;
    assign out_green    = out_res.pix.green;
    assign out_red      = out_res.pix.red;
    assign end_of_frame = out_res.end_of_frame;

endmodule

@@ rtl/bmf_checker.sv @@
// Port-level checks of the box mean filter, bound to the top level.
module bmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_blue,
    input logic [7:0]  out_green,
    input logic [7:0]  out_red,
    input logic        end_of_frame
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled result unchanged
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_blue) && $stable(out_green)
                                    && $stable(out_red) && $stable(end_of_frame))
        else $error("result changed while stalled");

    // Drop all results once reset has been seen at a clock edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

    // A result appears only after an input transaction that passed the pipeline and the output queue
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 5))
        else $error("result without a matching input transaction");

endmodule

bind box_mean_filter_rgb_unit bmf_checker u_bmf_checker (.*);
